// ----- design/pngw_pkg.sv -----
// Shared types, codes and constants for the PNG signature and chunk walker.
package pngw_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned OUT_DATA_W = 80;

    localparam logic [WORD_W-1:0] IEND_WORD = 32'h49454E44;
    localparam logic [WORD_W-1:0] CRC_BYTES = 32'd4;

    // Parser phases
    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_SKIP = 3'd3,
        PH_HALT = 3'd4
    } phase_t;

    // Reported event kinds
    typedef enum logic [KIND_W-1:0] {
        EV_SIG_OK  = 3'd0,
        EV_SIG_BAD = 3'd1,
        EV_HEADER  = 3'd2,
        EV_TRUNC   = 3'd3,
        EV_BAD_LEN = 3'd4
    } event_kind_t;

    // One accepted input request
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } in_item_t;

    // One result, with a flag that says whether the byte produced it
    typedef struct packed {
        logic              valid;
        event_kind_t       event_kind;
        logic [7:0]        mismatch_mask;
        logic [WORD_W-1:0] chunk_length;
        logic [WORD_W-1:0] chunk_type;
        logic              is_end;
    } result_t;

    // Expected signature byte at a given position
    function automatic logic [BYTE_W-1:0] sig_byte(input logic [2:0] idx);
        logic [BYTE_W-1:0] val;
        case (idx)
            3'd0:    val = 8'h89;
            3'd1:    val = 8'h50;
            3'd2:    val = 8'h4E;
            3'd3:    val = 8'h47;
            3'd4:    val = 8'h0D;
            3'd5:    val = 8'h0A;
            3'd6:    val = 8'h1A;
            3'd7:    val = 8'h0A;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// ----- design/png_signature_chunk_walker_unit.sv -----
// Top level of the PNG signature checker and chunk header walker.
//
//  channel | dir | ports                              | contents
//  --------+-----+------------------------------------+--------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata s_tlast  | one file byte, tlast = last byte
//  m_      | out | m_tvalid m_tready m_tdata m_tuser  | one event (signature, header, ...)
//
// One byte request is taken every cycle while m_ is not stalled; a byte passes the input register,
// the walker and the result register on its way to an event. The rate is set by the state update
// in the walker between the input register and the result register.
// aresetn is synchronous and active low; it returns the parser to the signature phase.
// A stalled m_ side holds its event and stops s_ after the input register fills.
module png_signature_chunk_walker_unit
    import pngw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // last_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] mismatch_mask, [39:8] chunk_length,
                                             // [71:40] chunk_type, [72] is_end, [79:73] zero
    output logic [KIND_W-1:0]     m_tuser    // [2:0] event_kind
);

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     out_free;
    logic     fire;
    result_t  res;
    result_t  m_res;

    assign s_item.data_byte = s_tdata;
    assign s_item.last_byte = s_tlast;

    // Process the held byte when the result register can take the outcome
    assign fire = item_valid && out_free;

    pngw_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    pngw_walker u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .res     (res)
    );

    pngw_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .res     (res),
        .free    (out_free),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (m_res)
    );

    // Pack the result fields
    assign m_tuser = m_res.event_kind;
    assign m_tdata = {7'd0, m_res.is_end, m_res.chunk_type,
                      m_res.chunk_length, m_res.mismatch_mask};

endmodule

// ----- design/pngw_in_stage.sv -----
// Input register stage: holds one byte request until the walker takes it.
module pngw_in_stage
    import pngw_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     take,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Free when empty or when the held request moves on this cycle
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ----- design/pngw_walker.sv -----
// Parser state and per-byte event logic for signature check and chunk walk.
module pngw_walker
    import pngw_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     fire,
    input  in_item_t item,
    output result_t  res
);

    phase_t            phase_reg, phase_next;
    logic [2:0]        count_reg, count_next;
    logic [7:0]        mism_reg, mism_next;
    logic [WORD_W-1:0] len_reg, len_next;
    logic [WORD_W-1:0] type_reg, type_next;
    logic [WORD_W-1:0] skip_reg, skip_next;

    logic [7:0]        mism_upd;
    logic [WORD_W-1:0] len_upd;
    logic [WORD_W-1:0] type_upd;
    logic [WORD_W-1:0] skip_dec;

    assign mism_upd = mism_reg
                    | ((item.data_byte != sig_byte(count_reg)) ? (8'd1 << count_reg) : 8'd0);
    assign len_upd  = {len_reg[WORD_W-BYTE_W-1:0], item.data_byte};
    assign type_upd = {type_reg[WORD_W-BYTE_W-1:0], item.data_byte};
    assign skip_dec = (skip_reg != '0) ? (skip_reg - WORD_W'(1)) : skip_reg;

    // Next state and result for the byte being processed
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        mism_next  = mism_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        skip_next  = skip_reg;
        res        = '0;

        case (phase_reg)
            PH_SIG: begin
                mism_next = mism_upd;
                if (count_reg == 3'd7) begin
                    count_next = '0;
                    res.valid  = 1'b1;
                    if (mism_upd == '0) begin
                        res.event_kind = EV_SIG_OK;
                        phase_next     = PH_LEN;
                        len_next       = '0;
                    end else begin
                        res.event_kind    = EV_SIG_BAD;
                        res.mismatch_mask = mism_upd;
                        phase_next        = PH_HALT;
                    end
                end else begin
                    count_next = count_reg + 3'd1;
                end
            end
            PH_LEN: begin
                len_next = len_upd;
                if (count_reg == 3'd3) begin
                    count_next = '0;
                    if (len_upd[WORD_W-1]) begin
                        res.valid        = 1'b1;
                        res.event_kind   = EV_BAD_LEN;
                        res.chunk_length = len_upd;
                        phase_next       = PH_HALT;
                    end else begin
                        phase_next = PH_TYPE;
                        type_next  = '0;
                    end
                end else begin
                    count_next = count_reg + 3'd1;
                end
            end
            PH_TYPE: begin
                type_next = type_upd;
                if (count_reg == 3'd3) begin
                    count_next       = '0;
                    res.valid        = 1'b1;
                    res.event_kind   = EV_HEADER;
                    res.chunk_length = len_reg;
                    res.chunk_type   = type_upd;
                    res.is_end       = (type_upd == IEND_WORD);
                    if (type_upd == IEND_WORD) begin
                        phase_next = PH_HALT;
                    end else begin
                        skip_next  = len_reg + CRC_BYTES;
                        phase_next = PH_SKIP;
                    end
                end else begin
                    count_next = count_reg + 3'd1;
                end
            end
            PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    phase_next = PH_LEN;
                    count_next = '0;
                    len_next   = '0;
                end
            end
            default: begin
                phase_next = PH_HALT;
            end
        endcase

        // End of stream: flag truncation unless the byte made an event or the parser halts, then return to reset state
        if (item.last_byte) begin
            if (!res.valid && phase_next != PH_HALT) begin
                res            = '0;
                res.valid      = 1'b1;
                res.event_kind = EV_TRUNC;
            end
            phase_next = PH_SIG;
            count_next = '0;
            mism_next  = '0;
            len_next   = '0;
            type_next  = '0;
            skip_next  = '0;
        end
    end

    // Advance state only when a byte is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SIG;
            count_reg <= '0;
            mism_reg  <= '0;
            len_reg   <= '0;
            type_reg  <= '0;
            skip_reg  <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            mism_reg  <= mism_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

// ----- design/pngw_out_stage.sv -----
// Result register stage: holds one event until the downstream takes it.
module pngw_out_stage
    import pngw_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  result_t res,
    output logic    free,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    // Load on a processed byte, drop once taken
    always_comb begin
        valid_next = valid_reg;
        if (fire) begin
            valid_next = res.valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res.valid) begin
            res_reg <= res;
        end
    end

endmodule
